### rtl/kvtnm_pkg.sv
`timescale 1ns / 1ps

package kvtnm_pkg;

    // Operation codes of the input beat
    typedef enum logic [2:0] {
        OP_PUSH    = 3'd0,
        OP_POP     = 3'd1,
        OP_SET_AT  = 3'd2,
        OP_SET_KEY = 3'd3,
        OP_GET_KEY = 3'd4,
        OP_CLEAR   = 3'd5
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } result_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_RESP
    } fsm_state_t;

    // Controller -> datapath
    typedef struct packed {
        logic load;       // capture the input beat
        logic exec;       // run a non-scan operation
        logic scan_start; // issue the read of entry zero
        logic scan_step;  // compare one entry, issue the next read
        logic out_load;   // move the result into the output register
    } dp_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic key_op; // operation needs a key scan
        logic empty;  // no used entries
        logic hit;    // entry under compare is the selected match
        logic last;   // entry under compare is the last used one
    } dp_sts_t;

endpackage

### rtl/kvtnm_dp.sv
`timescale 1ns / 1ps

module kvtnm_dp #(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_BITS    = 32,
    parameter int VALUE_BITS  = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  kvtnm_pkg::dp_cmd_t   cmd,
    output kvtnm_pkg::dp_sts_t   sts,
    input  logic [2:0]           in_op,
    input  logic [5:0]           in_idx,
    input  logic [31:0]          in_key,
    input  logic [31:0]          in_val,
    input  logic                 cfg_wr,
    input  logic [5:0]           cfg_wdata,
    output logic [5:0]           rank,
    output logic [1:0]           out_status,
    output logic [31:0]          out_found,
    output logic [5:0]           out_pos,
    output logic [6:0]           out_used
);

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int KW  = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam int VW  = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    localparam int XW  = (CW > 6) ? CW : 6;

    logic [KW+VW-1:0]     entry_mem [TABLE_DEPTH];
    logic [KW+VW-1:0]     rd_data_reg;

    kvtnm_pkg::op_t       op_reg;
    logic [5:0]           idx_reg;
    logic [KW-1:0]        key_reg;
    logic [VW-1:0]        val_reg;
    logic [CW-1:0]        count_reg, count_next;
    logic [5:0]           rank_reg;
    logic [AW-1:0]        scan_ptr_reg, scan_ptr_next;
    logic [CW-1:0]        seen_reg, seen_next;
    kvtnm_pkg::result_t   res_status_reg, res_status_next;
    logic [VW-1:0]        res_found_reg, res_found_next;
    logic [AW-1:0]        res_pos_reg, res_pos_next;
    logic [1:0]           out_status_reg;
    logic [31:0]          out_found_reg;
    logic [5:0]           out_pos_reg;
    logic [6:0]           out_used_reg;

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [KW-1:0]        rd_key;
    logic [VW-1:0]        rd_val;
    logic                 key_eq;
    logic                 full;
    logic                 idx_ok;

    assign rd_key = rd_data_reg[KW+VW-1:VW];
    assign rd_val = rd_data_reg[VW-1:0];
    assign key_eq = (rd_key == key_reg);
    assign full   = (count_reg == CW'(TABLE_DEPTH));
    assign idx_ok = (XW'(idx_reg) < XW'(count_reg));

    assign sts.key_op = (op_reg == kvtnm_pkg::OP_SET_KEY) || (op_reg == kvtnm_pkg::OP_GET_KEY);
    assign sts.empty  = (count_reg == '0);
    assign sts.hit    = key_eq && (XW'(seen_reg) == XW'(rank_reg));
    assign sts.last   = ((CW'(scan_ptr_reg) + CW'(1)) == count_reg);

    // read of entry zero on start, then one entry ahead of the compare
    assign rd_en   = cmd.scan_start || cmd.scan_step;
    assign rd_addr = cmd.scan_start ? '0 : scan_ptr_reg + AW'(1);

    always_comb begin
        wr_en           = 1'b0;
        wr_addr         = scan_ptr_reg;
        count_next      = count_reg;
        scan_ptr_next   = scan_ptr_reg;
        seen_next       = seen_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_pos_next    = res_pos_reg;

        if (cmd.exec) begin
            res_status_next = kvtnm_pkg::ST_MISS;
            res_found_next  = '0;
            res_pos_next    = '0;
            case (op_reg)
                kvtnm_pkg::OP_PUSH: begin
                    if (full) begin
                        res_status_next = kvtnm_pkg::ST_FULL;
                    end else begin
                        wr_en           = 1'b1;
                        wr_addr         = AW'(count_reg);
                        count_next      = count_reg + CW'(1);
                        res_status_next = kvtnm_pkg::ST_OK;
                    end
                end
                kvtnm_pkg::OP_POP: begin
                    if (!sts.empty) begin
                        count_next      = count_reg - CW'(1);
                        res_status_next = kvtnm_pkg::ST_OK;
                    end
                end
                kvtnm_pkg::OP_SET_AT: begin
                    if (idx_ok) begin
                        wr_en           = 1'b1;
                        wr_addr         = AW'(idx_reg);
                        res_status_next = kvtnm_pkg::ST_OK;
                    end
                end
                kvtnm_pkg::OP_CLEAR: begin
                    count_next      = '0;
                    res_status_next = kvtnm_pkg::ST_OK;
                end
                default: begin
                end
            endcase
        end

        if (cmd.scan_start) begin
            scan_ptr_next = '0;
            seen_next     = '0;
        end

        if (cmd.scan_step) begin
            if (sts.hit) begin
                res_status_next = kvtnm_pkg::ST_OK;
                res_pos_next    = scan_ptr_reg;
                if (op_reg == kvtnm_pkg::OP_GET_KEY) begin
                    res_found_next = rd_val;
                end else begin
                    res_found_next = '0;
                    wr_en          = 1'b1;
                    wr_addr        = scan_ptr_reg;
                end
            end else if (sts.last) begin
                res_status_next = kvtnm_pkg::ST_MISS;
                res_found_next  = '0;
                res_pos_next    = '0;
            end else begin
                scan_ptr_next = scan_ptr_reg + AW'(1);
                seen_next     = seen_reg + CW'(key_eq);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_mem[wr_addr] <= {key_reg, val_reg};
        end
        if (rd_en) begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            rank_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (cfg_wr) begin
                rank_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= kvtnm_pkg::op_t'(in_op);
            idx_reg <= in_idx;
            key_reg <= KW'(in_key);
            val_reg <= VW'(in_val);
        end
        scan_ptr_reg   <= scan_ptr_next;
        seen_reg       <= seen_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_pos_reg    <= res_pos_next;
        if (cmd.out_load) begin
            out_status_reg <= res_status_reg;
            out_found_reg  <= 32'(res_found_reg);
            out_pos_reg    <= 6'(res_pos_reg);
            out_used_reg   <= 7'(count_reg);
        end
    end

    assign rank       = rank_reg;
    assign out_status = out_status_reg;
    assign out_found  = out_found_reg;
    assign out_pos    = out_pos_reg;
    assign out_used   = out_used_reg;

`ifndef NO_ASSERTIONS
    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && op_reg == kvtnm_pkg::OP_PUSH && !full)
        |=> count_reg == CW'($past(count_reg) + CW'(1)))
        else $error("push did not grow the table");

    a_scan_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_start |-> !sts.empty)
        else $error("scan started on an empty table");

    a_hit_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.scan_step && sts.hit) |=> res_status_reg == kvtnm_pkg::ST_OK)
        else $error("hit did not report ok");
`endif

endmodule

### rtl/kvtnm_ctrl.sv
`timescale 1ns / 1ps

module kvtnm_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  kvtnm_pkg::dp_sts_t  sts,
    output kvtnm_pkg::dp_cmd_t  cmd
);

    kvtnm_pkg::fsm_state_t state_reg, state_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            kvtnm_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = kvtnm_pkg::S_DECODE;
                end
            end
            kvtnm_pkg::S_DECODE: begin
                if (sts.key_op && !sts.empty) begin
                    state_next = kvtnm_pkg::S_SCAN;
                end else begin
                    state_next = kvtnm_pkg::S_RESP;
                end
            end
            kvtnm_pkg::S_SCAN: begin
                if (sts.hit || sts.last) begin
                    state_next = kvtnm_pkg::S_RESP;
                end
            end
            kvtnm_pkg::S_RESP: begin
                if (out_free) begin
                    state_next = kvtnm_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = kvtnm_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        case (state_reg)
            kvtnm_pkg::S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            kvtnm_pkg::S_DECODE: begin
                // key ops on an empty table fall through exec as a miss
                if (sts.key_op && !sts.empty) begin
                    cmd.scan_start = 1'b1;
                end else begin
                    cmd.exec = 1'b1;
                end
            end
            kvtnm_pkg::S_SCAN: begin
                cmd.scan_step = 1'b1;
            end
            kvtnm_pkg::S_RESP: begin
                cmd.out_load = out_free;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= kvtnm_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

`ifndef NO_ASSERTIONS
    a_accept_decodes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> state_reg == kvtnm_pkg::S_DECODE)
        else $error("accepted beat not decoded");

    a_scan_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == kvtnm_pkg::S_SCAN && !sts.hit && !sts.last)
        |=> state_reg == kvtnm_pkg::S_SCAN)
        else $error("scan left early");

    a_result_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid_reg)
        else $error("loaded result not presented");
`endif

endmodule

### rtl/key_value_table_nth_match_core.sv
`timescale 1ns / 1ps

// Channel   Ports                                                 Beat
// input     s_valid/s_ready, s_operation, s_entry_index,          one operation
//           s_lookup_key, s_new_value
// result    m_valid/m_ready, m_status, m_found_value,             one result
//           m_match_index, m_entries_used
// config    psel/penable/pwrite/paddr/pwdata/prdata/pready        match_rank at 0x0
//
// Push, pop, assign at index, clear, unknown codes, key ops on an empty table: decode
//   executes the operation, then the response state loads the result; no new beat meanwhile.
// Key ops: scan reads one entry per cycle from the synchronous table memory and stops
//   at the selected match on a hit or at the last used entry on a miss.
// Next beat is taken the cycle after the result moves to the output register.
// Reset (aresetn, sync) empties the table and zeroes match_rank; no clearing pass.
// A stalled m_ready holds the output register; the core finishes the next
//   operation and waits in its response state.

module key_value_table_nth_match_core #(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_BITS    = 32,
    parameter int VALUE_BITS  = 32
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_operation,
    input  logic [5:0]  s_entry_index,
    input  logic [31:0] s_lookup_key,
    input  logic [31:0] s_new_value,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_found_value,
    output logic [5:0]  m_match_index,
    output logic [6:0]  m_entries_used,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    kvtnm_pkg::dp_cmd_t cmd;
    kvtnm_pkg::dp_sts_t sts;
    logic               cfg_wr;
    logic               rank_sel;
    logic [5:0]         rank;

    // Single register; paddr[2] set is beyond the map and reads zero.
    assign rank_sel = !paddr[2];
    assign cfg_wr   = psel && penable && pwrite && rank_sel;
    assign pready   = 1'b1;
    assign prdata   = rank_sel ? 32'(rank) : '0;

    kvtnm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    kvtnm_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .in_op      (s_operation),
        .in_idx     (s_entry_index),
        .in_key     (s_lookup_key),
        .in_val     (s_new_value),
        .cfg_wr     (cfg_wr),
        .cfg_wdata  (pwdata[5:0]),
        .rank       (rank),
        .out_status (m_status),
        .out_found  (m_found_value),
        .out_pos    (m_match_index),
        .out_used   (m_entries_used)
    );

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

// Random and directed test of the key/value table with nth-match lookup.
// A mirror of the table predicts every result beat; the sink compares field by field.
// Traffic runs in phases, and match_rank is changed over APB between phases,
// only once the core is drained.

module tb_top;

    localparam int          DEPTH     = 64;
    localparam int          MAX_IDLE  = 10;
    localparam logic [2:0]  RANK_ADDR = 3'd0;   // match_rank, register 0
    // operation codes the core must answer with a miss
    localparam logic [2:0]  OP_BAD_LO = 3'd6;
    localparam logic [2:0]  OP_BAD_HI = 3'd7;

    typedef enum int {
        PH_MIX,
        PH_FILL,
        PH_DRAIN,
        PH_ONE_KEY
    } phase_mode_t;

    typedef struct packed {
        kvtnm_pkg::result_t status;
        logic [31:0]        found_value;
        logic [5:0]         match_index;
        logic [6:0]         entries_used;
    } kv_result_t;

    // Mirror of the table contents, plus the queue of result beats still owed.
    class table_mirror;
        logic [31:0] keys [DEPTH];
        logic [31:0] vals [DEPTH];
        int          used;
        logic [5:0]  rank;
        int          fails;
        kv_result_t  owed_results [$];

        function new();
            used  = 0;
            rank  = '0;
            fails = 0;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        // position of the entry with key equal to 'key' whose rank among equal keys is 'rank'
        function bit find_nth(input logic [31:0] key, output int pos);
            int seen;
            seen = 0;
            pos  = 0;
            for (int i = 0; i < used; i++) begin
                if (keys[i] == key) begin
                    if (seen == rank) begin
                        pos = i;
                        return 1'b1;
                    end
                    seen++;
                end
            end
            return 1'b0;
        endfunction

        function void note_op(input logic [2:0] op, input logic [5:0] idx,
                              input logic [31:0] key, input logic [31:0] val);
            kv_result_t r;
            int         pos;
            r.status      = kvtnm_pkg::ST_MISS;
            r.found_value = '0;
            r.match_index = '0;
            case (op)
                kvtnm_pkg::OP_PUSH: begin
                    if (used >= DEPTH) begin
                        r.status = kvtnm_pkg::ST_FULL;
                    end else begin
                        keys[used] = key;
                        vals[used] = val;
                        used++;
                        r.status = kvtnm_pkg::ST_OK;
                    end
                end
                kvtnm_pkg::OP_POP: begin
                    if (used > 0) begin
                        used--;
                        r.status = kvtnm_pkg::ST_OK;
                    end
                end
                kvtnm_pkg::OP_SET_AT: begin
                    if (idx < used) begin
                        keys[idx] = key;
                        vals[idx] = val;
                        r.status  = kvtnm_pkg::ST_OK;
                    end
                end
                kvtnm_pkg::OP_SET_KEY: begin
                    if (find_nth(key, pos)) begin
                        vals[pos]     = val;
                        r.status      = kvtnm_pkg::ST_OK;
                        r.match_index = pos[5:0];
                    end
                end
                kvtnm_pkg::OP_GET_KEY: begin
                    if (find_nth(key, pos)) begin
                        r.found_value = vals[pos];
                        r.status      = kvtnm_pkg::ST_OK;
                        r.match_index = pos[5:0];
                    end
                end
                kvtnm_pkg::OP_CLEAR: begin
                    used     = 0;
                    r.status = kvtnm_pkg::ST_OK;
                end
                default: ;
            endcase
            r.entries_used = used[6:0];
            owed_results.push_back(r);
        endfunction

        function void check_result(input kv_result_t got);
            kv_result_t want;
            if (owed_results.size() == 0) begin
                $error("result beat with nothing owed: status %0d value %h index %0d used %0d",
                       got.status, got.found_value, got.match_index, got.entries_used);
                fails++;
                return;
            end
            want = owed_results.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                fails++;
            end
            if (got.found_value !== want.found_value) begin
                $error("found_value: expected %h, got %h", want.found_value, got.found_value);
                fails++;
            end
            if (got.match_index !== want.match_index) begin
                $error("match_index: expected %0d, got %0d", want.match_index, got.match_index);
                fails++;
            end
            if (got.entries_used !== want.entries_used) begin
                $error("entries_used: expected %0d, got %0d", want.entries_used,
                       got.entries_used);
                fails++;
            end
        endfunction
    endclass

    // Clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Input beat
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [2:0]  s_operation   = '0;
    logic [5:0]  s_entry_index = '0;
    logic [31:0] s_lookup_key  = '0;
    logic [31:0] s_new_value   = '0;

    // Result beat
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [1:0]  m_status;
    logic [31:0] m_found_value;
    logic [5:0]  m_match_index;
    logic [6:0]  m_entries_used;

    // APB
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    key_value_table_nth_match_core DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_entry_index  (s_entry_index),
        .s_lookup_key   (s_lookup_key),
        .s_new_value    (s_new_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_found_value  (m_found_value),
        .m_match_index  (m_match_index),
        .m_entries_used (m_entries_used),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    table_mirror sb;
    bit          calm;             // both sides run without gaps while set
    logic [31:0] key_pool [4];     // small key set per phase so equal keys pile up

    // One APB transfer. Bus is left selected; the caller releases it, so a
    // write can be followed by a read without touching psel twice in one step.
    task automatic apb_xfer(input bit wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= RANK_ADDR;
        pwdata  <= wdata;
        @(posedge aclk);                    // setup
        penable <= 1'b1;
        do @(posedge aclk); while (!pready); // access, register written here
        rdata = prdata;
    endtask

    // Write match_rank with junk in the upper bits, read it back.
    task automatic set_rank(input logic [5:0] r);
        logic [31:0] junk;
        logic [31:0] rd;
        junk = $urandom();
        apb_xfer(1'b1, {junk[31:6], r}, rd);
        sb.rank = r;
        apb_xfer(1'b0, '0, rd);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== {26'd0, r}) begin
            $error("match_rank readback: expected %h, got %h", {26'd0, r}, rd);
            sb.fails++;
        end
    endtask

    // Drive one operation beat; returns at the edge that accepts it.
    task automatic send_op(input logic [2:0] op, input logic [5:0] idx,
                           input logic [31:0] key, input logic [31:0] val);
        int gap;
        if ($urandom_range(0, 39) == 0)
            calm = !calm;
        gap = calm ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_operation   <= op;
        s_entry_index <= idx;
        s_lookup_key  <= key;
        s_new_value   <= val;
        do @(posedge aclk); while (!s_ready);
        sb.note_op(op, idx, key, val);
    endtask

    // Every beat owes exactly one result, so an empty queue means the core is idle.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_key();
        if ($urandom_range(0, 9) < 8)
            return key_pool[$urandom_range(0, 3)];
        return $urandom();
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // Op mix per phase: FILL runs into a full table, DRAIN into an empty one,
    // ONE_KEY stacks a single key so high ranks can hit.
    function automatic logic [2:0] pick_op(input phase_mode_t mode);
        int         roll;
        logic [2:0] bad;
        roll = $urandom_range(0, 99);
        bad  = $urandom_range(0, 1) ? OP_BAD_HI : OP_BAD_LO;
        case (mode)
            PH_FILL: begin
                if (roll < 60) return kvtnm_pkg::OP_PUSH;
                if (roll < 80) return kvtnm_pkg::OP_GET_KEY;
                if (roll < 88) return kvtnm_pkg::OP_SET_KEY;
                if (roll < 95) return kvtnm_pkg::OP_SET_AT;
                if (roll < 98) return kvtnm_pkg::OP_POP;
                return bad;
            end
            PH_DRAIN: begin
                if (roll < 50) return kvtnm_pkg::OP_POP;
                if (roll < 60) return kvtnm_pkg::OP_PUSH;
                if (roll < 78) return kvtnm_pkg::OP_GET_KEY;
                if (roll < 88) return kvtnm_pkg::OP_SET_KEY;
                if (roll < 95) return kvtnm_pkg::OP_SET_AT;
                if (roll < 97) return kvtnm_pkg::OP_CLEAR;
                return bad;
            end
            PH_ONE_KEY: begin
                if (roll < 70) return kvtnm_pkg::OP_PUSH;
                if (roll < 90) return kvtnm_pkg::OP_GET_KEY;
                if (roll < 97) return kvtnm_pkg::OP_SET_KEY;
                return kvtnm_pkg::OP_POP;
            end
            default: begin
                if (roll < 30) return kvtnm_pkg::OP_PUSH;
                if (roll < 42) return kvtnm_pkg::OP_POP;
                if (roll < 56) return kvtnm_pkg::OP_SET_AT;
                if (roll < 70) return kvtnm_pkg::OP_SET_KEY;
                if (roll < 94) return kvtnm_pkg::OP_GET_KEY;
                if (roll < 97) return kvtnm_pkg::OP_CLEAR;
                return bad;
            end
        endcase
    endfunction

    task automatic run_phase(input logic [5:0] r, input phase_mode_t mode, input int n_ops);
        logic [2:0]  op;
        logic [5:0]  idx;
        logic [31:0] key;
        wait_idle();
        set_rank(r);
        key_pool[0] = $urandom();
        key_pool[1] = $urandom();
        key_pool[2] = $urandom_range(0, 1) ? '1 : '0;
        key_pool[3] = key_pool[0] ^ (32'd1 << $urandom_range(0, 31));  // near miss
        if (mode == PH_ONE_KEY)
            send_op(kvtnm_pkg::OP_CLEAR, 6'($urandom()), $urandom(), $urandom());
        repeat (n_ops) begin
            op = pick_op(mode);
            if (sb.used != 0 && $urandom_range(0, 4) != 0)
                idx = 6'($urandom_range(0, sb.used - 1));
            else
                idx = 6'($urandom_range(0, DEPTH - 1));
            key = (mode == PH_ONE_KEY && op == kvtnm_pkg::OP_PUSH) ? key_pool[0] : pick_key();
            send_op(op, idx, key, pick_value());
        end
    endtask

    // Result sink: random stall before each beat, ready held until it lands.
    initial begin : result_sink
        int          stall;
        kv_result_t  got;
        while (!aresetn)
            @(posedge aclk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got.status       = kvtnm_pkg::result_t'(m_status);
            got.found_value  = m_found_value;
            got.match_index  = m_match_index;
            got.entries_used = m_entries_used;
            sb.check_result(got);
        end
    end

    // Hang guard: several times the slowest legal run.
    initial begin : watchdog
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        logic [31:0] rd;
        sb = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // match_rank must come out of reset at zero
        apb_xfer(1'b0, '0, rd);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== 32'd0) begin
            $error("match_rank after reset: expected %h, got %h", 32'd0, rd);
            sb.fails++;
        end

        // Directed: everything against an empty table first
        send_op(kvtnm_pkg::OP_POP,     6'd0,  32'd0,        32'd0);
        send_op(kvtnm_pkg::OP_GET_KEY, 6'd0,  32'd0,        32'd0);
        send_op(kvtnm_pkg::OP_SET_AT,  6'd0,  32'hFFFFFFFF, 32'hFFFFFFFF);
        send_op(kvtnm_pkg::OP_SET_KEY, 6'd63, 32'h0,        32'h1);
        // extreme keys and values
        send_op(kvtnm_pkg::OP_PUSH,    6'd0,  32'h00000000, 32'hFFFFFFFF);
        send_op(kvtnm_pkg::OP_PUSH,    6'd63, 32'hFFFFFFFF, 32'h00000000);
        send_op(kvtnm_pkg::OP_PUSH,    6'd0,  32'h00000000, 32'h12345678);
        send_op(kvtnm_pkg::OP_GET_KEY, 6'd0,  32'h00000000, 32'h0);
        send_op(kvtnm_pkg::OP_GET_KEY, 6'd0,  32'hFFFFFFFF, 32'h0);
        // index beyond the used entries, then a legal overwrite of key and value
        send_op(kvtnm_pkg::OP_SET_AT,  6'd63, 32'hA5A5A5A5, 32'h5A5A5A5A);
        send_op(kvtnm_pkg::OP_SET_AT,  6'd2,  32'hA5A5A5A5, 32'h5A5A5A5A);
        send_op(kvtnm_pkg::OP_SET_KEY, 6'd0,  32'hFFFFFFFF, 32'h0F0F0F0F);
        send_op(kvtnm_pkg::OP_GET_KEY, 6'd0,  32'hFFFFFFFF, 32'h0);
        send_op(kvtnm_pkg::OP_GET_KEY, 6'd0,  32'hDEADBEEF, 32'h0);   // miss
        send_op(OP_BAD_LO,             6'd63, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_op(OP_BAD_HI,             6'd0,  32'h0,        32'h0);
        send_op(kvtnm_pkg::OP_POP,     6'd0,  32'h0,        32'h0);
        send_op(kvtnm_pkg::OP_CLEAR,   6'd0,  32'h0,        32'h0);
        send_op(kvtnm_pkg::OP_GET_KEY, 6'd0,  32'h0,        32'h0);   // gone after clear

        // second occurrence of an equal key
        wait_idle();
        set_rank(6'd1);
        send_op(kvtnm_pkg::OP_PUSH,    6'd0,  32'h0,        32'h11111111);
        send_op(kvtnm_pkg::OP_PUSH,    6'd0,  32'h0,        32'h22222222);
        send_op(kvtnm_pkg::OP_GET_KEY, 6'd0,  32'h0,        32'h0);
        send_op(kvtnm_pkg::OP_SET_KEY, 6'd0,  32'h0,        32'h33333333);
        send_op(kvtnm_pkg::OP_GET_KEY, 6'd0,  32'h0,        32'h0);

        // Random phases; the 63 phase fills the table with one key so the last slot hits
        run_phase(6'd0,                     PH_MIX,     150);
        run_phase(6'd63,                    PH_ONE_KEY, 150);
        run_phase(6'd1,                     PH_FILL,    150);
        run_phase(6'd0,                     PH_DRAIN,   100);
        run_phase(6'd2,                     PH_MIX,     150);
        run_phase(6'($urandom_range(0, 63)), PH_ONE_KEY, 120);
        run_phase(6'd3,                     PH_FILL,    150);
        run_phase(6'd0,                     PH_DRAIN,    80);
        run_phase(6'($urandom_range(0, 7)), PH_MIX,     200);

        // drain, then leave room for a stray beat to show up
        wait_idle();
        repeat (80) @(posedge aclk);
        if (sb.pending() != 0) begin
            $error("%0d result beats never arrived", sb.pending());
            sb.fails++;
        end
        if (sb.fails == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
